@@ design/cse_pkg.sv @@
// Shared types, register codes and small lookup functions for the
// constant-strain triangle stiffness block. No dependencies.
package cse_pkg;

	localparam int COORD_W = 32;
	localparam int DIFF_W  = 33;
	localparam int ADET_W  = 67;
	localparam int ENTRY_W = 64;
	localparam int NUM_COLS = 6;
	localparam int IN_W    = 6 * COORD_W;
	localparam int OUT_W   = NUM_COLS * ENTRY_W;
	localparam int USER_W  = 4;

	localparam logic [2:0] REG_D11 = 3'd0;
	localparam logic [2:0] REG_D12 = 3'd1;
	localparam logic [2:0] REG_D13 = 3'd2;
	localparam logic [2:0] REG_D22 = 3'd3;
	localparam logic [2:0] REG_D23 = 3'd4;
	localparam logic [2:0] REG_D33 = 3'd5;

	localparam logic [2:0] LAST_ROW = 3'd5;
	localparam logic [2:0] LAST_COL = 3'd5;

	localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [COORD_W-1:0] mat_entry_t;

	// One classified element: node differences, |det| and the zero-area flag.
	typedef struct packed {
		diff_t b0;
		diff_t b1;
		diff_t b2;
		diff_t c0;
		diff_t c1;
		diff_t c2;
		logic [ADET_W-1:0] adet;
		logic degen;
	} elem_t;

	typedef struct packed {
		mat_entry_t d11;
		mat_entry_t d12;
		mat_entry_t d13;
		mat_entry_t d22;
		mat_entry_t d23;
		mat_entry_t d33;
	} mat_t;

	// Entry of the strain-displacement matrix, row k, dof column col.
	function automatic diff_t bhat(elem_t e, logic [1:0] k, logic [2:0] col);
		diff_t bi;
		diff_t ci;
		diff_t r;
		case (col[2:1])
			2'd0: begin
				bi = e.b0;
				ci = e.c0;
			end
			2'd1: begin
				bi = e.b1;
				ci = e.c1;
			end
			default: begin
				bi = e.b2;
				ci = e.c2;
			end
		endcase
		case (k)
			2'd0: r = col[0] ? '0 : bi;
			2'd1: r = col[0] ? ci : '0;
			default: r = col[0] ? bi : ci;
		endcase
		return r;
	endfunction

	// Symmetric material matrix entry D[k][l].
	function automatic mat_entry_t dmat(mat_t m, logic [1:0] k, logic [1:0] l);
		mat_entry_t r;
		case ({k, l})
			4'b0000: r = m.d11;
			4'b0001, 4'b0100: r = m.d12;
			4'b0010, 4'b1000: r = m.d13;
			4'b0101: r = m.d22;
			4'b0110, 4'b1001: r = m.d23;
			default: r = m.d33;
		endcase
		return r;
	endfunction

endpackage

@@ design/cse_front.sv @@
// Front end: accepts triangles, forms node differences and the determinant.
// Depends on cse_pkg.
module cse_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [cse_pkg::IN_W-1:0]  s_tdata,
	input  logic                      q_full,
	output logic                      push,
	output cse_pkg::elem_t            elem
);

	logic adv;
	logic v_s1, v_s2, v_s3;
	cse_pkg::diff_t b0_s1, b1_s1, b2_s1, c0_s1, c1_s1, c2_s1;
	cse_pkg::diff_t b0_s2, b1_s2, b2_s2, c0_s2, c1_s2, c2_s2;
	logic signed [65:0] p1_s2, p2_s2;
	logic signed [66:0] det;
	cse_pkg::elem_t elem_s3;

	logic signed [31:0] x0, y0, x1, y1, x2, y2;

	assign x0 = s_tdata[31:0];
	assign y0 = s_tdata[63:32];
	assign x1 = s_tdata[95:64];
	assign y1 = s_tdata[127:96];
	assign x2 = s_tdata[159:128];
	assign y2 = s_tdata[191:160];

	// The whole front stalls only when its last stage cannot push.
	assign adv      = !v_s3 || !q_full;
	assign s_tready = adv;
	assign push     = v_s3 && !q_full;
	assign elem     = elem_s3;

	assign det = {p1_s2[65], p1_s2} - {p2_s2[65], p2_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b0_s1 <= {y1[31], y1} - {y2[31], y2};
			b1_s1 <= {y2[31], y2} - {y0[31], y0};
			b2_s1 <= {y0[31], y0} - {y1[31], y1};
			c0_s1 <= {x2[31], x2} - {x1[31], x1};
			c1_s1 <= {x0[31], x0} - {x2[31], x2};
			c2_s1 <= {x1[31], x1} - {x0[31], x0};

			p1_s2 <= c2_s1 * b1_s1;
			p2_s2 <= c1_s1 * b2_s1;
			b0_s2 <= b0_s1;
			b1_s2 <= b1_s1;
			b2_s2 <= b2_s1;
			c0_s2 <= c0_s1;
			c1_s2 <= c1_s1;
			c2_s2 <= c2_s1;

			elem_s3.b0    <= b0_s2;
			elem_s3.b1    <= b1_s2;
			elem_s3.b2    <= b2_s2;
			elem_s3.c0    <= c0_s2;
			elem_s3.c1    <= c1_s2;
			elem_s3.c2    <= c2_s2;
			elem_s3.adet  <= det[66] ? 67'(-det) : 67'(det);
			elem_s3.degen <= (det == '0);
		end
	end

endmodule

@@ design/cse_queue.sv @@
// Short queue of classified elements between the front and back ends.
// Depends on cse_pkg.
module cse_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cse_pkg::elem_t push_data,
	output logic           full,
	input  logic           pop,
	output cse_pkg::elem_t pop_data,
	output logic           empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cse_pkg::elem_t mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

endmodule

@@ design/cse_back.sv @@
// Back end: sequences numerator products, the rounding divider and row output.
// Depends on cse_pkg.
module cse_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	output logic                        q_pop,
	input  cse_pkg::elem_t              q_data,
	input  cse_pkg::mat_t               mat,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [cse_pkg::OUT_W-1:0]   m_tdata,
	output logic [cse_pkg::USER_W-1:0]  m_tuser,
	output logic                        m_tlast
);

	localparam int SHIFT = 33 - FRAC_BITS;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_DRAIN, ST_MAG, ST_CHK, ST_DIV, ST_FIN, ST_EMIT
	} state_t;

	typedef enum logic [1:0] {TAG_NONE, TAG_T, TAG_LO, TAG_HI} tag_t;

	state_t state_q;
	tag_t tag_q;
	cse_pkg::elem_t el_q;
	logic [2:0] row_q, col_q;
	logic [1:0] k_q, l_q, ph_q;
	logic [5:0] cnt_q;
	logic big_q, neg_q;
	logic signed [67:0] prod_q;
	logic signed [64:0] t_q;
	logic signed [103:0] acc_q;
	logic [127:0] mag_q;
	logic [69:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] colv_q [cse_pkg::NUM_COLS];

	logic out_free, acc_clr, big, ge;
	cse_pkg::diff_t bh_ki, bh_lj;
	cse_pkg::mat_entry_t dkl;
	logic signed [33:0] mul_a, mul_b;
	logic signed [67:0] mul_p;
	logic [69:0] den4;
	logic [103:0] acc_abs;
	logic [127:0] mag_n;
	logic [70:0] rem_sh;
	logic [63:0] sat_val;

	assign out_free = !m_tvalid || m_tready;
	assign q_pop    = (state_q == ST_IDLE) && !q_empty;

	assign acc_clr = q_pop
		|| (state_q == ST_FIN && col_q != cse_pkg::LAST_COL)
		|| (state_q == ST_EMIT && out_free && row_q != cse_pkg::LAST_ROW);

	assign bh_ki = cse_pkg::bhat(el_q, k_q, row_q);
	assign bh_lj = cse_pkg::bhat(el_q, l_q, col_q);
	assign dkl   = cse_pkg::dmat(mat, k_q, l_q);

	// One shared multiplier: t = Bhat[k][i]*D[k][l], then t*Bhat[l][j] in halves.
	always_comb begin
		case (ph_q)
			2'd0: begin
				mul_a = {bh_ki[32], bh_ki};
				mul_b = {{2{dkl[31]}}, dkl};
			end
			2'd1: begin
				mul_a = {2'b00, prod_q[31:0]};
				mul_b = {bh_lj[32], bh_lj};
			end
			default: begin
				mul_a = {t_q[64], t_q[64:32]};
				mul_b = {bh_lj[32], bh_lj};
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign den4    = {1'b0, el_q.adet, 2'b00};
	assign acc_abs = acc_q[103] ? 104'(-acc_q) : 104'(acc_q);
	assign mag_n   = ({24'b0, acc_abs} << SHIFT) + {60'b0, el_q.adet, 1'b0};
	assign big     = {6'b0, mag_q[127:64]} >= den4;
	assign rem_sh  = {rem_q, mag_q[63]};
	assign ge      = rem_sh >= {1'b0, den4};

	always_comb begin
		if (neg_q) begin
			if (big_q || quo_q > cse_pkg::MIN64)
				sat_val = cse_pkg::MIN64;
			else
				sat_val = -quo_q;
		end else begin
			if (big_q || quo_q[63])
				sat_val = cse_pkg::MAX64;
			else
				sat_val = quo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			tag_q    <= TAG_NONE;
			row_q    <= '0;
			col_q    <= '0;
			k_q      <= '0;
			l_q      <= '0;
			ph_q     <= '0;
			cnt_q    <= '0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tuser  <= '0;
			m_tlast  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						row_q   <= '0;
						col_q   <= '0;
						k_q     <= '0;
						l_q     <= '0;
						ph_q    <= '0;
						state_q <= q_data.degen ? ST_EMIT : ST_MUL;
					end
				end
				ST_MUL: begin
					if (ph_q == 2'd2) begin
						ph_q <= '0;
						if (l_q == 2'd2) begin
							l_q <= '0;
							if (k_q == 2'd2) begin
								k_q     <= '0;
								state_q <= ST_DRAIN;
							end else begin
								k_q <= k_q + 1'b1;
							end
						end else begin
							l_q <= l_q + 1'b1;
						end
					end else begin
						ph_q <= ph_q + 1'b1;
					end
				end
				ST_DRAIN: state_q <= ST_MAG;
				ST_MAG:   state_q <= ST_CHK;
				ST_CHK: begin
					cnt_q   <= '0;
					state_q <= big ? ST_FIN : ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'd63)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (col_q == cse_pkg::LAST_COL) begin
						state_q <= ST_EMIT;
					end else begin
						col_q   <= col_q + 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						for (int j = 0; j < cse_pkg::NUM_COLS; j++)
							m_tdata[j*cse_pkg::ENTRY_W +: cse_pkg::ENTRY_W] <=
								el_q.degen ? '0 : colv_q[j];
						m_tuser <= {el_q.degen, row_q};
						m_tlast <= (row_q == cse_pkg::LAST_ROW);
						if (row_q == cse_pkg::LAST_ROW) begin
							state_q <= ST_IDLE;
						end else begin
							row_q   <= row_q + 1'b1;
							col_q   <= '0;
							state_q <= el_q.degen ? ST_EMIT : ST_MUL;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_EMIT && out_free)
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
			// The tag follows the multiplier phase, registered.
			if (state_q != ST_MUL)
				tag_q <= TAG_NONE;
			else if (ph_q == 2'd0)
				tag_q <= TAG_T;
			else if (ph_q == 2'd1)
				tag_q <= TAG_LO;
			else
				tag_q <= TAG_HI;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (tag_q == TAG_T)
			t_q <= prod_q[64:0];
		if (acc_clr) begin
			acc_q <= '0;
		end else begin
			case (tag_q)
				TAG_LO: acc_q <= acc_q + {{36{prod_q[67]}}, prod_q};
				TAG_HI: acc_q <= acc_q + {{4{prod_q[67]}}, prod_q, 32'b0};
				default: ;
			endcase
		end
		if (q_pop)
			el_q <= q_data;
		if (state_q == ST_MAG) begin
			mag_q <= mag_n;
			neg_q <= acc_q[103];
		end
		if (state_q == ST_CHK) begin
			big_q <= big;
			rem_q <= {6'b0, mag_q[127:64]};
		end
		if (state_q == ST_DIV) begin
			rem_q <= ge ? 70'(rem_sh - {1'b0, den4}) : rem_sh[69:0];
			quo_q <= {quo_q[62:0], ge};
			mag_q <= mag_q << 1;
		end
		if (state_q == ST_FIN)
			colv_q[col_q] <= sat_val;
	end

endmodule

@@ design/cst_element_stiffness_top.sv @@
// Top level of the constant-strain triangle stiffness block.
// Depends on cse_pkg, cse_front, cse_queue and cse_back.

// A triangle enters on the slave stream as six signed fixed-point coordinates
// and leaves as six rows of its 6x6 element stiffness matrix in signed Q32.32,
// saturated and rounded to nearest with ties away from zero. The front end
// forms the node differences and the determinant in three pipeline stages and
// drops the result into a short element queue, so new triangles are taken
// while the back end is still busy. The back end computes each entry with one
// shared multiplier for the nine numerator terms and a restoring divider that
// settles one quotient bit per cycle. A zero-area element skips the arithmetic
// and produces its six rows at one row per cycle when the output is not
// stalled, with all entries zero and the degenerate flag set. The material
// matrix must be written through the configuration port only while the block
// is idle; the block itself does not enforce this. Writes to unused indexes
// are ignored.
module cst_element_stiffness_top #(
	parameter int FRAC_BITS   = 16,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// node0_x, node0_y, node1_x, node1_y, node2_x, node2_y (32 bits each)
	input  logic [191:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// k_col0, k_col1, k_col2, k_col3, k_col4, k_col5 (64 bits each)
	output logic [383:0] m_tdata,
	// row_index (3 bits), degenerate (1 bit)
	output logic [3:0]   m_tuser,
	output logic         m_tlast,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	cse_pkg::mat_t mat_q;
	cse_pkg::elem_t push_elem, pop_elem;
	logic push, q_full, q_pop, q_empty;

	// Material matrix registers; the symmetric half is shared by lookup.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				cse_pkg::REG_D11: mat_q.d11 <= cfg_data;
				cse_pkg::REG_D12: mat_q.d12 <= cfg_data;
				cse_pkg::REG_D13: mat_q.d13 <= cfg_data;
				cse_pkg::REG_D22: mat_q.d22 <= cfg_data;
				cse_pkg::REG_D23: mat_q.d23 <= cfg_data;
				cse_pkg::REG_D33: mat_q.d33 <= cfg_data;
				default: ;
			endcase
		end
	end

	cse_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.push     (push),
		.elem     (push_elem)
	);

	cse_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_elem),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_elem),
		.empty     (q_empty)
	);

	cse_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.q_data   (pop_elem),
		.mat      (mat_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

@@ design/cse_checker.sv @@
// Port-level checks on the output rows of the stiffness block, and the bind
// that attaches them to the top level. Depends on cst_element_stiffness_top.
module cse_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [383:0] m_tdata,
	input logic [3:0]   m_tuser,
	input logic         m_tlast
);

	logic [2:0] exp_row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			exp_row_q <= '0;
		else if (m_tvalid && m_tready)
			exp_row_q <= m_tlast ? 3'd0 : exp_row_q + 1'b1;
	end

	// Rows of an element leave in order, starting from row zero.
	a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[2:0] == exp_row_q))
		else $error("output row out of sequence");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser[2:0] == cse_pkg::LAST_ROW)))
		else $error("tlast does not match the final row");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[3]) |-> (m_tdata == '0))
		else $error("degenerate row carries nonzero entries");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled output item changed");

endmodule

bind cst_element_stiffness_top cse_checker u_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for cst_element_stiffness_top: random triangles and material
// matrices go in, and each stiffness row that comes out is checked against a local predictor.
// Depends on cse_pkg and the design sources.
module tb_top;

	localparam int FRAC = 16;
	localparam int WIDE = 200;

	typedef logic signed [WIDE-1:0] wide_t;

	// One stiffness row as it should leave the block.
	typedef struct {
		logic [2:0]       row_index;
		logic [5:0][63:0] k_col;
		logic             last_row;
		logic             degenerate;
	} stiff_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [191:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [383:0] m_tdata;
	logic [3:0]   m_tuser;
	logic         m_tlast;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [31:0]  cfg_data;

	// Triangles waiting to be sent, and the rows they are expected to produce.
	logic [191:0] tri_pending[$];
	stiff_row_t   rows_expected[$];

	// Local copy of the material matrix, updated on every register write.
	logic signed [31:0] mat[3][3];

	logic hold_sender;
	int   send_gap;
	int   recv_gap;
	int   mismatches;
	bit   failed;

	cst_element_stiffness_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Gap lengths: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// Entry of the strain-displacement matrix before division by the area.
	function automatic wide_t strain_entry(wide_t b[3], wide_t c[3], int k, int col);
		int node;
		node = col / 2;
		case (k)
			0: return (col % 2 == 0) ? b[node] : wide_t'(0);
			1: return (col % 2 == 1) ? c[node] : wide_t'(0);
			default: return (col % 2 == 0) ? c[node] : b[node];
		endcase
	endfunction

	// Works out the six rows of Ke = Bhat^T D Bhat / (2|d|) for one triangle.
	task automatic predict_stiffness(input logic [191:0] tri_data);
		wide_t x[3], y[3], b[3], c[3];
		wide_t det, adet, num, mag, quo, term;
		stiff_row_t row;
		bit degen;
		for (int n = 0; n < 3; n++) begin
			x[n] = wide_t'($signed(tri_data[64*n +: 32]));
			y[n] = wide_t'($signed(tri_data[64*n+32 +: 32]));
		end
		b[0] = y[1] - y[2];
		b[1] = y[2] - y[0];
		b[2] = y[0] - y[1];
		c[0] = x[2] - x[1];
		c[1] = x[0] - x[2];
		c[2] = x[1] - x[0];
		det = c[2] * b[1] - c[1] * b[2];
		degen = (det == 0);
		adet = (det < 0) ? -det : det;
		for (int i = 0; i < 6; i++) begin
			row.row_index = 3'(i);
			row.last_row = (i == 5);
			row.degenerate = degen;
			for (int j = 0; j < 6; j++) begin
				row.k_col[j] = '0;
				if (!degen) begin
					num = 0;
					for (int k = 0; k < 3; k++)
						for (int l = 0; l < 3; l++) begin
							term = strain_entry(b, c, k, i) * wide_t'(mat[k][l]);
							num += term * strain_entry(b, c, l, j);
						end
					mag = (num < 0) ? -num : num;
					// Round to nearest, ties away from zero, on the magnitude.
					mag = (mag <<< (33 - FRAC)) + (adet <<< 1);
					quo = mag / (adet <<< 2);
					if (num < 0)
						row.k_col[j] = (quo > (wide_t'(1) <<< 63)) ? cse_pkg::MIN64 :
							64'(-quo);
					else
						row.k_col[j] = (quo > wide_t'(cse_pkg::MAX64)) ? cse_pkg::MAX64 :
							64'(quo);
				end
			end
			rows_expected.push_back(row);
		end
	endtask

	// Sender: one item on the slave stream at a time, fed from tri_pending.
	always @(posedge clk or negedge arst_n) begin
		logic fire;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			send_gap = 0;
		end else begin
			fire = s_tvalid && s_tready;
			if (fire) begin
				predict_stiffness(s_tdata);
				send_gap = pick_gap();
			end
			if (s_tvalid && !fire) begin
				// Hold the current item until it is taken.
			end else if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (!hold_sender && tri_pending.size() > 0) begin
				s_tdata <= tri_pending.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random back-pressure, each accepted row checked against the oldest
	// expectation.
	always @(posedge clk or negedge arst_n) begin
		stiff_row_t want;
		bit bad;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (rows_expected.size() == 0) begin
					failed = 1'b1;
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected row: user=%h last=%b", m_tuser, m_tlast);
				end else begin
					want = rows_expected.pop_front();
					bad = (m_tuser[2:0] !== want.row_index) ||
						(m_tuser[3] !== want.degenerate) ||
						(m_tlast !== want.last_row);
					for (int j = 0; j < 6; j++)
						if (m_tdata[64*j +: 64] !== want.k_col[j])
							bad = 1'b1;
					if (bad) begin
						failed = 1'b1;
						mismatches++;
						if (mismatches <= 10) begin
							$display("row mismatch: exp row=%0d degen=%b last=%b",
								want.row_index, want.degenerate, want.last_row);
							$display("  got row=%0d degen=%b last=%b",
								m_tuser[2:0], m_tuser[3], m_tlast);
							for (int j = 0; j < 6; j++)
								$display("  col%0d exp=%h got=%h", j, want.k_col[j],
									m_tdata[64*j +: 64]);
						end
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(3) == 0)
					recv_gap = pick_gap();
			end
		end
	end

	// Register write while the block is idle; the local matrix follows it.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			cse_pkg::REG_D11: mat[0][0] = val;
			cse_pkg::REG_D12: begin
				mat[0][1] = val;
				mat[1][0] = val;
			end
			cse_pkg::REG_D13: begin
				mat[0][2] = val;
				mat[2][0] = val;
			end
			cse_pkg::REG_D22: mat[1][1] = val;
			cse_pkg::REG_D23: begin
				mat[1][2] = val;
				mat[2][1] = val;
			end
			cse_pkg::REG_D33: mat[2][2] = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_matrix(input logic [31:0] v[6]);
		for (int r = 0; r < 6; r++)
			write_reg(3'(r), v[r]);
	endtask

	task automatic wait_idle();
		while (tri_pending.size() != 0 || s_tvalid || rows_expected.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [191:0] pack_tri(int x0, int y0, int x1, int y1, int x2, int y2);
		return {y2, x2, y1, x1, y0, x0};
	endfunction

	// Random triangle of one of several shapes: full-range, small, degenerate, wide.
	function automatic logic [191:0] random_tri();
		int r, x0, y0, x1, y1, dx, dy, s;
		r = $urandom_range(99);
		if (r < 30)
			return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		if (r < 65) begin
			x0 = $signed($urandom_range(2 ** 22)) - 2 ** 21;
			y0 = $signed($urandom_range(2 ** 22)) - 2 ** 21;
			return pack_tri(x0, y0,
				x0 + $signed($urandom_range(2 ** 20)) - 2 ** 19,
				y0 + $signed($urandom_range(2 ** 20)) - 2 ** 19,
				x0 + $signed($urandom_range(2 ** 20)) - 2 ** 19,
				y0 + $signed($urandom_range(2 ** 20)) - 2 ** 19);
		end
		if (r < 85) begin
			// Zero area: repeated node or three collinear nodes.
			x0 = $signed($urandom_range(2 ** 24)) - 2 ** 23;
			y0 = $signed($urandom_range(2 ** 24)) - 2 ** 23;
			dx = $signed($urandom_range(2 ** 20)) - 2 ** 19;
			dy = $signed($urandom_range(2 ** 20)) - 2 ** 19;
			s = $urandom_range(3) - 1;
			case ($urandom_range(2))
				0: return pack_tri(x0, y0, x0, y0, x0 + dx, y0 + dy);
				1: return pack_tri(x0, y0, x0 + dx, y0 + dy, x0 + dx, y0 + dy);
				default: return pack_tri(x0, y0, x0 + dx, y0 + dy, x0 + s * dx, y0 + s * dy);
			endcase
		end
		x1 = $urandom;
		y1 = $urandom;
		return pack_tri(32'h8000_0000 + $urandom_range(255), $urandom,
			x1, y1, 32'h7FFF_FFFF - $urandom_range(255), $urandom);
	endfunction

	initial begin
		logic [31:0] mset[6];
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_sender = 1'b0;
		mismatches = 0;
		failed = 1'b0;
		for (int k = 0; k < 3; k++)
			for (int l = 0; l < 3; l++)
				mat[k][l] = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with a plane-stress-like matrix; writes to unused indexes
		// must leave it unchanged.
		mset = '{32'h0001_0000, 32'h0000_4CCD, 32'h0000_0000, 32'h0001_0000,
			32'h0000_0000, 32'h0000_599A};
		write_matrix(mset);
		write_reg(3'd6, 32'hDEAD_BEEF);
		write_reg(3'd7, 32'h1234_5678);
		tri_pending.push_back(pack_tri(0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000));
		tri_pending.push_back(pack_tri(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0));
		tri_pending.push_back(pack_tri(0, 0, 0, 0, 0, 0));
		tri_pending.push_back(pack_tri(5, 7, 5, 7, 9, 1));
		tri_pending.push_back(pack_tri(0, 0, 2, 2, 4, 4));
		tri_pending.push_back(pack_tri(0, 0, 1, 0, 0, 1));
		tri_pending.push_back(pack_tri(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
		tri_pending.push_back(pack_tri(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
		tri_pending.push_back(pack_tri(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		tri_pending.push_back(pack_tri(-1, -1, -1, -1, -1, -1));
		tri_pending.push_back(pack_tri(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 0, 1));
		tri_pending.push_back(pack_tri(0, 0, 1, 0, 0, 32'h7FFF_FFFF));
		tri_pending.push_back(pack_tri(0, 0, 3, 0, 0, 3));
		tri_pending.push_back(pack_tri(32'h0010_0000, 32'h0020_0000, 32'hFFF0_0000,
			32'h0005_0000, 32'h0003_0000, 32'hFFE0_0000));
		wait_idle();

		// Extreme and random matrices, each with a batch of random triangles.
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: mset = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
					32'h7FFF_FFFF, 32'h7FFF_FFFF};
				1: mset = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
					32'h8000_0000, 32'h8000_0000};
				2: mset = '{0, 0, 0, 0, 0, 0};
				3: mset = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
					32'h7FFF_FFFF, 32'h8000_0000};
				default: for (int r = 0; r < 6; r++)
					mset[r] = ($urandom_range(1)) ? $urandom :
						32'($signed($urandom_range(2 ** 20)) - 2 ** 19);
			endcase
			write_matrix(mset);
			for (int n = 0; n < 76; n++) begin
				tri_pending.push_back(random_tri());
				// Midway through one phase the sender waits for all rows to drain.
				if (phase == 4 && n == 38) begin
					while (tri_pending.size() != 0 || s_tvalid)
						@(posedge clk);
					hold_sender = 1'b1;
					while (rows_expected.size() != 0)
						@(posedge clk);
					hold_sender = 1'b0;
				end
			end
			wait_idle();
		end

		if (!failed)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	// Roughly 470 elements, with the time they need taken several times over.
	initial begin
		#(64'd150_000_000);
		$display("tb_top NOT OK");
		$finish;
	end

endmodule

@@ files.f @@
design/cse_pkg.sv
design/cse_front.sv
design/cse_queue.sv
design/cse_back.sv
design/cst_element_stiffness_top.sv
design/cse_checker.sv
tb/tb_top.sv
